// ===== design/srr_pkg.sv =====
// Shared constants and controller/datapath interface types for the reorder release buffer.
package srr_pkg;

   // Widths fixed by the transaction fields
   localparam int FIELD_W  = 16;
   localparam int CFG_W    = 5;
   localparam int STATUS_W = 2;
   localparam int REQ_DATA_W = 3 * FIELD_W;
   localparam int RSP_DATA_W = 3 * FIELD_W;

   // Parameter defaults
   localparam int WINDOW_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF     = 16;

   // Longest release run one completion may cause
   localparam int RUN_MAX = 16;

   // Window register reset value
   localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd16;

   // Request kinds
   localparam logic MODE_ALLOC    = 1'b0;
   localparam logic MODE_COMPLETE = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_GRANT   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RELEASE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_grant;
      logic load_full;
      logic load_outside;
      logic store;
      logic ram_read;
      logic load_release;
   } srr_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic full;
      logic outside;
      logic head_hit;
      logic run_last;
      logic out_free;
   } srr_sts_type;

endpackage

// ===== design/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srr_ram
   import srr_pkg::*;
#(
   parameter int WIDTH = 2 * FIELD_W,
   parameter int DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/srr_ctrl.sv =====
// Controller state machine: request acceptance and release run sequencing.
module srr_ctrl
   import srr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_mode,
   output logic        req_tready,
   input  srr_sts_type sts,
   output srr_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && sts.out_free;
   assign accept     = req_tvalid && req_tready;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ALLOC) begin
                  cmd.load_grant = !sts.full;
                  cmd.load_full  = sts.full;
               end else if (sts.outside) begin
                  cmd.load_outside = 1'b1;
               end else begin
                  cmd.store = 1'b1;
                  if (sts.head_hit) begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.load_release = 1'b1;
               state_in         = sts.run_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/srr_dpath.sv =====
// Datapath: tag counters, window register, slot store and response register.
module srr_dpath
   import srr_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int TAG_BITS     = TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CFG_W-1:0]      csr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  srr_cmd_type           cmd,
   output srr_sts_type           sts,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W   = $clog2(WINDOW_DEPTH);
   localparam int WIN_MAX = (WINDOW_DEPTH < RUN_MAX) ? WINDOW_DEPTH : RUN_MAX;
   localparam int SLOT_W  = 2 * FIELD_W;

   logic [CFG_W-1:0]        window_ff, window_in;
   logic [TAG_BITS-1:0]     issue_ff, issue_in;
   logic [TAG_BITS-1:0]     release_ff, release_in;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [FIELD_W-1:0]      rsp_handle_ff, rsp_handle_in;
   logic [FIELD_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [FIELD_W-1:0]      seq_tag;
   logic [SLOT_W-1:0]       slot_wdata;
   logic [SLOT_W-1:0]       slot_rdata;
   logic [TAG_BITS+FIELD_W-1:0] seq_ext, issue_ext, release_ext;
   logic [TAG_BITS-1:0]     tag;
   logic [TAG_BITS-1:0]     outstanding;
   logic [TAG_BITS-1:0]     offset;
   logic [TAG_BITS-1:0]     release_next;
   logic [CFG_W-1:0]        eff_window;
   logic [IDX_W-1:0]        tag_idx, release_idx, release_next_idx;

   assign seq_tag    = req_tdata[FIELD_W-1:0];
   assign slot_wdata = req_tdata[3*FIELD_W-1:FIELD_W];

   // Map tags between field width and counter width
   assign seq_ext     = {{TAG_BITS{1'b0}}, seq_tag};
   assign issue_ext   = {{FIELD_W{1'b0}}, issue_ff};
   assign release_ext = {{FIELD_W{1'b0}}, release_ff};
   assign tag         = seq_ext[TAG_BITS-1:0];

   // Clamp the window to one and to the smaller of the slot count and RUN_MAX
   always_comb begin
      if (window_ff == '0) begin
         eff_window = CFG_W'(1);
      end else if (window_ff > CFG_W'(WIN_MAX)) begin
         eff_window = CFG_W'(WIN_MAX);
      end else begin
         eff_window = window_ff;
      end
   end

   assign outstanding      = issue_ff - release_ff;
   assign offset           = tag - release_ff;
   assign release_next     = release_ff + TAG_BITS'(1);
   assign tag_idx          = tag[IDX_W-1:0];
   assign release_idx      = release_ff[IDX_W-1:0];
   assign release_next_idx = release_next[IDX_W-1:0];

   // Report status to the controller
   assign sts.full     = outstanding >= TAG_BITS'(eff_window);
   assign sts.outside  = offset >= outstanding;
   assign sts.head_hit = offset == '0;
   assign sts.run_last = (release_next == issue_ff) || !valid_ff[release_next_idx];
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // Slot payload store
   srr_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (tag_idx),
      .wr_data (slot_wdata),
      .rd_en   (cmd.ram_read),
      .rd_addr (release_idx),
      .rd_data (slot_rdata)
   );

   // Advance counters, slot valid bits and window register
   always_comb begin
      window_in  = csr_valid ? csr_data : window_ff;
      issue_in   = cmd.load_grant ? issue_ff + TAG_BITS'(1) : issue_ff;
      release_in = cmd.load_release ? release_next : release_ff;
      valid_in   = valid_ff;
      if (cmd.store) begin
         valid_in[tag_idx] = 1'b1;
      end
      if (cmd.load_release) begin
         valid_in[release_idx] = 1'b0;
      end
   end

   // Load the response register, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_grant || cmd.load_full || cmd.load_outside) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = '0;
         rsp_count_in  = '0;
         rsp_last_in   = 1'b1;
         if (cmd.load_grant) begin
            rsp_status_in = ST_GRANT;
            rsp_tag_in    = issue_ext[FIELD_W-1:0];
         end else if (cmd.load_full) begin
            rsp_status_in = ST_FULL;
            rsp_tag_in    = '0;
         end else begin
            rsp_status_in = ST_OUTSIDE;
            rsp_tag_in    = seq_tag;
         end
      end else if (cmd.load_release) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_RELEASE;
         rsp_tag_in    = release_ext[FIELD_W-1:0];
         rsp_handle_in = slot_rdata[FIELD_W-1:0];
         rsp_count_in  = slot_rdata[SLOT_W-1:FIELD_W];
         rsp_last_in   = sts.run_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         issue_ff     <= '0;
         release_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         issue_ff     <= issue_in;
         release_ff   <= release_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_handle_ff, rsp_tag_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== design/sequence_reorder_release.sv =====
// Top level of the in-order release buffer for out-of-order completions.
// Allocate transactions (tuser 0) return the next sequence tag, or a window-full status
// when the configured number of tags is outstanding; completion transactions (tuser 1)
// store a buffer handle and byte count under their tag and, when the tag is the oldest
// outstanding one, release every stored entry in tag order, tlast marking the end of
// the run. Allocations, out-of-window completions and completions that only store are
// taken while the response register is free or draining. A release run reads each entry
// from the slot RAM (registered read) and loads it when the response register is free,
// taking no new request until the run ends. The user must write the window register
// through the csr channel only while no transaction is in progress, which the block
// itself does not enforce; 0 acts as 1 and values above the slot count or 16 saturate.
module sequence_reorder_release
   import srr_pkg::*;
#(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
   parameter int TAG_BITS     = TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Window size register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data,
   // Requests
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // seq_tag, buf_handle, byte_count
   input  logic [0:0]            req_tuser,  // mode
   // Responses
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // tag_out, handle_out, count_out
   output logic [STATUS_W-1:0]   rsp_tuser,  // status
   output logic                  rsp_tlast
);

   srr_cmd_type cmd;
   srr_sts_type sts;

   assign csr_ready = 1'b1;

   srr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser[0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   srr_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .TAG_BITS     (TAG_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A completion at the head starts a slot read in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] && !sts.outside && sts.head_hit
      |=> cmd.ram_read)
      else $error("release run did not start after head completion");

   // No request is taken while a slot read is in flight
   assert property (@(posedge clock) disable iff (reset)
      cmd.ram_read |=> !req_tready)
      else $error("request accepted during release run");

   // Only in-window completions are stored
   assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> !sts.outside)
      else $error("out-of-window completion stored");

   // A released entry is loaded only into a free response register
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_release |-> sts.out_free && !req_tready)
      else $error("release loaded over a pending response");

endmodule

// ===== sim/sequence_reorder_release_tb.sv =====
// Self-checking testbench for the in-order release buffer: predicts and checks every response.
module sequence_reorder_release_tb
   import srr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = WINDOW_DEPTH_DEF;
   localparam int PHASE_ITEMS = 34;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  tag;
      logic [FIELD_W-1:0]  handle;
      logic [FIELD_W-1:0]  count;
      logic                last;
   } release_rsp_type;

   // Predicted buffer state and the responses it still owes
   class release_scoreboard_type;
      bit [CFG_W-1:0]   window_reg;
      bit [FIELD_W-1:0] issue_tag;
      bit [FIELD_W-1:0] release_tag;
      bit               slot_full [DEPTH];
      bit [FIELD_W-1:0] slot_handle [DEPTH];
      bit [FIELD_W-1:0] slot_count [DEPTH];
      release_rsp_type  due_results [$];
      int               errors, requests, grants, fulls, outsides, released, longest_run;
      bit               wrapped;

      function new();
         window_reg = WINDOW_RESET;
      endfunction

      // Zero acts as one; saturate at the slot count and the run limit
      function int unsigned window_limit();
         int unsigned w;
         w = window_reg;
         if (w < 1) w = 1;
         if (w > DEPTH) w = DEPTH;
         if (w > RUN_MAX) w = RUN_MAX;
         return w;
      endfunction

      function int unsigned outstanding();
         bit [FIELD_W-1:0] diff;
         diff = issue_tag - release_tag;
         return diff;
      endfunction

      function bit is_stored(bit [FIELD_W-1:0] tag);
         return slot_full[tag % DEPTH];
      endfunction

      function bit head_ready(int run);
         return run < RUN_MAX && release_tag != issue_tag && slot_full[release_tag % DEPTH];
      endfunction

      function void note_request(bit mode, bit [FIELD_W-1:0] tag, bit [FIELD_W-1:0] handle,
                                 bit [FIELD_W-1:0] count);
         release_rsp_type  item;
         bit [FIELD_W-1:0] offset;
         int               idx;
         int               run;
         requests++;
         item = '0;
         item.last = 1'b1;
         if (mode == MODE_ALLOC) begin
            if (outstanding() >= window_limit()) begin
               item.status = ST_FULL;
               fulls++;
            end else begin
               item.status = ST_GRANT;
               item.tag = issue_tag;
               issue_tag++;
               grants++;
               if (issue_tag == '0) wrapped = 1'b1;
            end
            due_results.push_back(item);
            return;
         end
         // Reject tags that are not outstanding
         offset = tag - release_tag;
         if (offset >= outstanding()) begin
            item.status = ST_OUTSIDE;
            item.tag = tag;
            outsides++;
            due_results.push_back(item);
            return;
         end
         idx = tag % DEPTH;
         slot_full[idx] = 1'b1;
         slot_handle[idx] = handle;
         slot_count[idx] = count;
         // Release stored entries in tag order from the head
         run = 0;
         while (head_ready(run)) begin
            idx = release_tag % DEPTH;
            item.status = ST_RELEASE;
            item.tag = release_tag;
            item.handle = slot_handle[idx];
            item.count = slot_count[idx];
            slot_full[idx] = 1'b0;
            release_tag++;
            run++;
            item.last = !head_ready(run);
            due_results.push_back(item);
         end
         released += run;
         if (run > longest_run) longest_run = run;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(release_rsp_type got);
         release_rsp_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual status %0d tag %0h",
                     $time, got.status, got.tag);
            return;
         end
         want = due_results.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("tag_out", want.tag, got.tag);
         compare_field("handle_out", want.handle, got.handle);
         compare_field("count_out", want.count, got.count);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // seq_tag, buf_handle, byte_count
   logic [0:0]            req_tuser = '0;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // tag_out, handle_out, count_out
   logic [STATUS_W-1:0]   rsp_tuser;       // status
   logic                  rsp_tlast;

   release_scoreboard_type sb;
   bit                    idle_on = 1'b0;
   int                    stall_left = 0;
   int                    items_sent = 0;

   sequence_reorder_release dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stall the response side in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check responses, then predict from accepted requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result({rsp_tuser, rsp_tdata[FIELD_W-1:0],
                             rsp_tdata[2*FIELD_W-1:FIELD_W],
                             rsp_tdata[3*FIELD_W-1:2*FIELD_W], rsp_tlast});
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[0], req_tdata[FIELD_W-1:0],
                            req_tdata[2*FIELD_W-1:FIELD_W],
                            req_tdata[3*FIELD_W-1:2*FIELD_W]);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_req(bit mode, bit [FIELD_W-1:0] tag, bit [FIELD_W-1:0] handle,
                           bit [FIELD_W-1:0] count);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {count, handle, tag};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic bit [FIELD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return FIELD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic request_tag();
      send_req(MODE_ALLOC, pick_word(), pick_word(), pick_word());
   endtask

   task automatic complete_tag(bit [FIELD_W-1:0] tag);
      send_req(MODE_COMPLETE, tag, pick_word(), pick_word());
   endtask

   // Write the window register once the buffer has drained
   task automatic write_window(bit [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.due_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.window_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Fill the window, then complete every tag in random order with the head last
   task automatic flush_burst(bit with_full);
      int unsigned      k;
      int unsigned      pick;
      int               i;
      bit [FIELD_W-1:0] t;
      bit [FIELD_W-1:0] open_tags [$];
      k = sb.outstanding();
      while (k < sb.window_limit()) begin
         request_tag();
         k++;
      end
      if (with_full) request_tag();
      for (i = 1; i < sb.outstanding(); i++) begin
         t = sb.release_tag + FIELD_W'(i);
         if (!sb.is_stored(t)) open_tags.push_back(t);
      end
      while (open_tags.size() > 0) begin
         pick = $urandom_range(0, open_tags.size() - 1);
         complete_tag(open_tags[pick]);
         open_tags.delete(pick);
      end
      if (sb.outstanding() != 0) complete_tag(sb.release_tag);
   endtask

   // Mostly well-formed traffic, with repeats and out-of-window noise
   task automatic random_item();
      int unsigned      r;
      int               i;
      bit [FIELD_W-1:0] t;
      bit [FIELD_W-1:0] open_tags [$];
      bit [FIELD_W-1:0] held_tags [$];
      r = $urandom_range(0, 99);
      for (i = 0; i < sb.outstanding(); i++) begin
         t = sb.release_tag + FIELD_W'(i);
         if (sb.is_stored(t)) held_tags.push_back(t);
         else open_tags.push_back(t);
      end
      if (r < 30)
         request_tag();
      else if (r < 75 && open_tags.size() > 0)
         complete_tag(open_tags[$urandom_range(0, open_tags.size() - 1)]);
      else if (r < 82 && held_tags.size() > 0)
         complete_tag(held_tags[$urandom_range(0, held_tags.size() - 1)]);
      else if (r < 92) begin
         case ($urandom_range(0, 2))
            0: complete_tag(sb.issue_tag);
            1: complete_tag(sb.release_tag - 1'b1);
            default: complete_tag(sb.issue_tag + FIELD_W'($urandom_range(0, 40)));
         endcase
      end else
         complete_tag(FIELD_W'($urandom_range(0, 65535)));
   endtask

   task automatic random_phase();
      int start;
      start = items_sent;
      if (sb.window_limit() == RUN_MAX) flush_burst(1'b1);
      while (items_sent - start < PHASE_ITEMS) random_item();
   endtask

   initial begin
      bit [CFG_W-1:0] windows [7];
      int             p;
      int             guard;
      sb = new();
      windows = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd7};
      windows[4] = CFG_W'($urandom_range(2, 15));
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty window, edges, overwrite, runs of four and one
      idle_on = 1'b1;
      send_req(MODE_COMPLETE, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_req(MODE_COMPLETE, 16'hFFFF, 16'h0000, 16'h0000);
      repeat (4) send_req(MODE_ALLOC, 16'h0000, 16'h0000, 16'h0000);
      send_req(MODE_COMPLETE, 16'h0004, 16'h1111, 16'h2222);
      send_req(MODE_COMPLETE, 16'h0002, 16'h0000, 16'h0000);
      send_req(MODE_COMPLETE, 16'h0002, 16'hFFFF, 16'hFFFF);
      send_req(MODE_COMPLETE, 16'h0003, 16'h1234, 16'h4321);
      send_req(MODE_COMPLETE, 16'h0001, 16'h00FF, 16'hFF00);
      send_req(MODE_COMPLETE, 16'h0000, 16'hFFFF, 16'h0000);
      send_req(MODE_COMPLETE, 16'h0003, 16'h3333, 16'h3333);
      send_req(MODE_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_req(MODE_COMPLETE, 16'h0004, 16'h5555, 16'hAAAA);

      // Random phases over a spread of window settings
      for (p = 0; p < 7; p++) begin
         write_window(windows[p]);
         idle_on = (p != 3);
         random_phase();
      end

      // Finish at full rate with no idling on either side
      idle_on = 1'b0;
      write_window(5'd16);
      random_phase();
      flush_burst(1'b1);
      req_tvalid <= 1'b0;

      // Drain, then allow for any late response
      guard = 0;
      while (sb.due_results.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (60) @(negedge clock);
      if (sb.due_results.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d responses never arrived, expected status %0d tag %0h",
                  $time, sb.due_results.size(), sb.due_results[0].status,
                  sb.due_results[0].tag);
      end

      $display("Covered %0d requests: %0d grants, %0d window full, %0d out of window,",
               sb.requests, sb.grants, sb.fulls, sb.outsides);
      $display("%0d entries released (longest run %0d), tag wrap crossed: %0d",
               sb.released, sb.longest_run, sb.wrapped);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Hold a hard limit well above the slowest correct run
   initial begin
      #(64'd40_000_000);
      $display("Timeout at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
